FILE: hw/rtl/bsfr_pkg.sv
`default_nettype none
package bsfr_pkg;

  // Largest number of bytes that any single transaction can produce, and the
  // hard ceiling on pattern and replacement length.
  localparam int SLOTS = 16;
  localparam int LEN_W = 5;
  localparam int IDX_W = 4;

  // Depth of the queue between the classifying front end and the emitter.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  // One queued burst: up to SLOTS bytes to emit in order, their number, and
  // whether the final one closes the text. A zero count with last set is a
  // bare end marker.
  typedef struct packed {
    logic [8*SLOTS-1:0] payload;
    logic [LEN_W-1:0]   count;
    logic               last;
  } cmd_t;

endpackage
`default_nettype wire

FILE: hw/rtl/bsfr_front.sv
`default_nettype none
module bsfr_front #(
  parameter int MAX_PATTERN     = 16,
  parameter int MAX_REPLACEMENT = 16
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_we,
  input  wire logic [2:0]          cfg_index,
  input  wire logic [63:0]         cfg_wdata,
  input  wire logic                in_tvalid,
  output logic                     in_tready,
  input  wire logic [7:0]          in_data,
  input  wire logic                in_last,
  input  wire logic                q_full,
  output logic                     q_push,
  output bsfr_pkg::cmd_t           q_cmd
);

  localparam int WIN = (MAX_PATTERN < bsfr_pkg::SLOTS) ? MAX_PATTERN : bsfr_pkg::SLOTS;
  localparam int REP = (MAX_REPLACEMENT < bsfr_pkg::SLOTS) ? MAX_REPLACEMENT
                                                           : bsfr_pkg::SLOTS;
  localparam int IW = $clog2(WIN);
  localparam int FW = $clog2(WIN + 1);
  localparam logic [4:0] WIN_LEN = 5'(WIN);
  localparam logic [4:0] REP_LEN = 5'(REP);

  localparam logic [2:0] REG_PATTERN_LENGTH     = 3'd0;
  localparam logic [2:0] REG_PATTERN_LOW        = 3'd1;
  localparam logic [2:0] REG_PATTERN_HIGH       = 3'd2;
  localparam logic [2:0] REG_REPLACEMENT_LENGTH = 3'd3;
  localparam logic [2:0] REG_REPLACEMENT_LOW    = 3'd4;
  localparam logic [2:0] REG_REPLACEMENT_HIGH   = 3'd5;

  logic [4:0]    pat_len_r;
  logic [63:0]   pat_lo_r;
  logic [63:0]   pat_hi_r;
  logic [4:0]    rep_len_r;
  logic [63:0]   rep_lo_r;
  logic [63:0]   rep_hi_r;
  logic [FW-1:0] fill_r;
  logic [FW-1:0] fill_nxt;
  logic [7:0]    win_r   [WIN];
  logic [7:0]    win_nxt [WIN];
  logic [7:0]    wn      [WIN];

  logic [4:0]    plen;
  logic [4:0]    rlen;
  logic [4:0]    fill5;
  logic [4:0]    slot5;
  logic [4:0]    slot_plus;
  logic [IW-1:0] slot;
  logic [127:0]  pat_all;
  logic [127:0]  rep_all;
  logic          full;
  logic          match;
  logic          in_acc;

  assign in_tready = !q_full;
  assign in_acc    = in_tvalid && in_tready;
  assign pat_all   = {pat_hi_r, pat_lo_r};
  assign rep_all   = {rep_hi_r, rep_lo_r};

  // Effective lengths and the slot that the incoming byte lands in.
  always_comb begin
    plen      = (pat_len_r > WIN_LEN) ? WIN_LEN : pat_len_r;
    rlen      = (rep_len_r > REP_LEN) ? REP_LEN : rep_len_r;
    fill5     = 5'(fill_r);
    slot5     = (fill5 >= plen) ? 5'd0 : fill5;
    slot      = slot5[IW-1:0];
    slot_plus = slot5 + 5'd1;
    full      = (slot_plus == plen);
  end

  // Window with the new byte inserted, and its comparison with the pattern.
  always_comb begin
    match = 1'b1;
    for (int i = 0; i < WIN; i++) begin
      wn[i] = (slot == IW'(i)) ? in_data : win_r[i];
      if ((5'(i) < plen) && (wn[i] != pat_all[8*i +: 8])) begin
        match = 1'b0;
      end
    end
  end

  // Classify the transaction into at most one burst for the emitter.
  always_comb begin
    win_nxt       = wn;
    fill_nxt      = fill_r;
    q_push        = 1'b0;
    q_cmd         = '0;
    q_cmd.last    = in_last;
    for (int i = 0; i < WIN; i++) begin
      q_cmd.payload[8*i +: 8] = wn[i];
    end
    if (plen == 5'd0) begin
      // Pass-through: the byte sits in the lowest slot.
      q_cmd.count = 5'd1;
      q_push      = 1'b1;
      fill_nxt    = '0;
    end else if (full && match) begin
      q_cmd.payload = rep_all;
      q_cmd.count   = rlen;
      q_push        = in_last || (rlen != 5'd0);
      fill_nxt      = '0;
    end else if (full) begin
      q_push = 1'b1;
      if (in_last) begin
        q_cmd.count = plen;
        fill_nxt    = '0;
      end else begin
        q_cmd.count = 5'd1;
        fill_nxt    = FW'(plen - 5'd1);
        for (int i = 0; i < WIN - 1; i++) begin
          win_nxt[i] = wn[i+1];
        end
      end
    end else if (in_last) begin
      q_cmd.count = slot_plus;
      q_push      = 1'b1;
      fill_nxt    = '0;
    end else begin
      fill_nxt = FW'(slot_plus);
    end
    q_push = q_push && in_acc;
  end

  // Configuration registers and window fill level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_len_r <= '0;
      pat_lo_r  <= '0;
      pat_hi_r  <= '0;
      rep_len_r <= '0;
      rep_lo_r  <= '0;
      rep_hi_r  <= '0;
      fill_r    <= '0;
    end else begin
      // A write to the pattern length empties the window.
      if (cfg_we && (cfg_index == REG_PATTERN_LENGTH)) begin
        fill_r <= '0;
      end else if (in_acc) begin
        fill_r <= fill_nxt;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          REG_PATTERN_LENGTH:     pat_len_r <= cfg_wdata[4:0];
          REG_PATTERN_LOW:        pat_lo_r  <= cfg_wdata;
          REG_PATTERN_HIGH:       pat_hi_r  <= cfg_wdata;
          REG_REPLACEMENT_LENGTH: rep_len_r <= cfg_wdata[4:0];
          REG_REPLACEMENT_LOW:    rep_lo_r  <= cfg_wdata;
          REG_REPLACEMENT_HIGH:   rep_hi_r  <= cfg_wdata;
          default: begin
          end
        endcase
      end
    end
  end

  // Window bytes carry no reset; only the fill level says which are valid.
  always_ff @(posedge clk) begin
    if (in_acc && (plen != 5'd0)) begin
      win_r <= win_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/bsfr_queue.sv
`default_nettype none
module bsfr_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire bsfr_pkg::cmd_t  push_cmd,
  input  wire logic            pop,
  output bsfr_pkg::cmd_t       head,
  output logic                 empty,
  output logic                 full
);

  bsfr_pkg::cmd_t                   mem_r [bsfr_pkg::QDEPTH];
  logic [bsfr_pkg::QPTR_W-1:0]      wr_ptr_r;
  logic [bsfr_pkg::QPTR_W-1:0]      rd_ptr_r;
  logic [bsfr_pkg::QCNT_W-1:0]      cnt_r;
  logic                             do_push;
  logic                             do_pop;

  assign empty   = (cnt_r == '0);
  assign full    = (cnt_r == bsfr_pkg::QCNT_W'(bsfr_pkg::QDEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rd_ptr_r];

  // Pointers and occupancy.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/bsfr_back.sv
`default_nettype none
module bsfr_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire bsfr_pkg::cmd_t  head,
  input  wire logic            empty,
  output logic                 pop,
  output logic                 out_tvalid,
  input  wire logic            out_tready,
  output logic [7:0]           out_byte,
  output logic                 out_present,
  output logic                 out_last
);

  logic [bsfr_pkg::IDX_W-1:0] idx_r;
  logic                       valid_r;
  logic [7:0]                 byte_r;
  logic                       present_r;
  logic                       last_r;
  logic                       load;
  logic                       take;
  logic                       bare;
  logic                       final_byte;

  assign out_tvalid  = valid_r;
  assign out_byte    = byte_r;
  assign out_present = present_r;
  assign out_last    = last_r;

  // The output register refills when empty or when its transaction completes.
  assign load       = !valid_r || out_tready;
  assign take       = load && !empty;
  assign bare       = (head.count == '0);
  assign final_byte = bare || ((5'(idx_r) + 5'd1) == head.count);
  assign pop        = take && final_byte;

  // Control: output valid and position within the current burst.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else if (load) begin
      valid_r <= !empty;
      if (take) begin
        idx_r <= final_byte ? '0 : idx_r + 1'b1;
      end
    end
  end

  // Payload of the output register.
  always_ff @(posedge clk) begin
    if (take) begin
      byte_r    <= bare ? 8'd0 : head.payload[8*idx_r +: 8];
      present_r <= !bare;
      last_r    <= head.last && final_byte;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/byte_stream_find_replace.sv
// Streaming find-and-replace on a byte stream.
// Input channel in_*: one text byte per transaction in in_tdata, with in_tlast
// set on the final byte of a text. Output channel out_*: one result per
// transaction; out_tdata is the byte, out_tuser says a byte is present (a
// zero there is a bare end marker), out_tlast closes the output text.
// Configuration port cfg_*: six registers (pattern length, pattern bytes low
// and high, replacement length, replacement bytes low and high); the user must
// write them only while the block is idle (not enforced). Writing the pattern
// length empties the window. The front end classifies each accepted byte and
// queues a burst of up to 16 results; the emitter drains a burst at one result
// per cycle while out_tready is high, so an input byte is accepted every cycle
// until a replacement or flush burst fills the four-entry queue. Reset clears
// the configuration, the window fill level, the queue and the output register.
// When the receiver stalls the output register holds, the queue fills and
// in_tready falls; nothing is lost or repeated.
`default_nettype none
module byte_stream_find_replace #(
  parameter int MAX_PATTERN     = 16,
  parameter int MAX_REPLACEMENT = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_wdata,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] data_byte
  input  wire logic        in_tlast,   // end_of_text
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,  // [7:0] out_byte
  output logic             out_tuser,  // byte_present
  output logic             out_tlast   // out_last
);

  bsfr_pkg::cmd_t push_cmd;
  bsfr_pkg::cmd_t head;
  logic           push;
  logic           pop;
  logic           q_empty;
  logic           q_full;

  // Front end: configuration, window and classification.
  bsfr_front #(
    .MAX_PATTERN     (MAX_PATTERN),
    .MAX_REPLACEMENT (MAX_REPLACEMENT)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_data   (in_tdata),
    .in_last   (in_tlast),
    .q_full    (q_full),
    .q_push    (push),
    .q_cmd     (push_cmd)
  );

  // Burst queue between the two halves.
  bsfr_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty),
    .full     (q_full)
  );

  // Emitter with the output register.
  bsfr_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .head        (head),
    .empty       (q_empty),
    .pop         (pop),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_byte    (out_tdata),
    .out_present (out_tuser),
    .out_last    (out_tlast)
  );

endmodule
`default_nettype wire

FILE: bench/byte_stream_find_replace_tb.sv
module byte_stream_find_replace_tb;

  // Configuration register indexes, in the order of the register file.
  typedef enum logic [2:0] {
    REG_PAT_LEN = 3'd0,
    REG_PAT_LO  = 3'd1,
    REG_PAT_HI  = 3'd2,
    REG_REP_LEN = 3'd3,
    REG_REP_LO  = 3'd4,
    REG_REP_HI  = 3'd5
  } cfg_reg_e;

  localparam int SETTLE_CYCLES = 12;
  localparam int TARGET_ITEMS  = 270;

  // Predicts the edited text and checks every output transaction against it.
  class text_replacer_sb;
    typedef struct {
      bit [7:0] data;
      bit       present;
      bit       last;
    } text_result_t;

    bit [4:0]     pat_len_reg;
    bit [63:0]    pat_lo;
    bit [63:0]    pat_hi;
    bit [4:0]     rep_len_reg;
    bit [63:0]    rep_lo;
    bit [63:0]    rep_hi;
    bit [7:0]     window [16];
    int unsigned  fill;
    text_result_t expected_text[$];
    int unsigned  errors;

    function new();
      pat_len_reg = '0;
      pat_lo      = '0;
      pat_hi      = '0;
      rep_len_reg = '0;
      rep_lo      = '0;
      rep_hi      = '0;
      fill        = 0;
      errors      = 0;
    endfunction

    // Lengths above sixteen saturate at sixteen.
    function int unsigned eff_len(bit [4:0] len_reg);
      return (len_reg > 5'd16) ? 16 : int'(len_reg);
    endfunction

    function bit [7:0] pick_byte(bit [63:0] lo, bit [63:0] hi, int unsigned i);
      bit [127:0] both;
      both = {hi, lo};
      return both[8*i +: 8];
    endfunction

    function void write_reg(cfg_reg_e idx, bit [63:0] value);
      case (idx)
        REG_PAT_LEN: begin
          // A new pattern length drops whatever the window holds.
          pat_len_reg = value[4:0];
          fill        = 0;
        end
        REG_PAT_LO:  pat_lo      = value;
        REG_PAT_HI:  pat_hi      = value;
        REG_REP_LEN: rep_len_reg = value[4:0];
        REG_REP_LO:  rep_lo      = value;
        REG_REP_HI:  rep_hi      = value;
        default: ;
      endcase
    endfunction

    function void push_result(bit [7:0] data, bit present, bit last);
      text_result_t r;
      r.data    = data;
      r.present = present;
      r.last    = last;
      expected_text.push_back(r);
    endfunction

    // Works out the output transactions caused by one accepted input byte.
    function void note_input(bit [7:0] b, bit eot);
      int unsigned  plen;
      int unsigned  rlen;
      int unsigned  before_cnt;
      bit           hit;
      text_result_t tail;
      plen       = eff_len(pat_len_reg);
      rlen       = eff_len(rep_len_reg);
      before_cnt = expected_text.size();
      if (plen == 0) begin
        fill = 0;
        push_result(b, 1'b1, eot);
        return;
      end
      if (fill >= plen) fill = 0;
      window[fill] = b;
      fill++;
      if (fill == plen) begin
        hit = 1'b1;
        for (int unsigned i = 0; i < plen; i++) begin
          if (window[i] != pick_byte(pat_lo, pat_hi, i)) hit = 1'b0;
        end
        if (hit) begin
          for (int unsigned i = 0; i < rlen; i++) begin
            push_result(pick_byte(rep_lo, rep_hi, i), 1'b1, 1'b0);
          end
          fill = 0;
        end else begin
          push_result(window[0], 1'b1, 1'b0);
          for (int unsigned i = 0; i + 1 < plen; i++) window[i] = window[i+1];
          fill--;
        end
      end
      // End of text: flush the window and mark the final transaction.
      if (eot) begin
        for (int unsigned i = 0; i < fill; i++) push_result(window[i], 1'b1, 1'b0);
        fill = 0;
        if (expected_text.size() == before_cnt) begin
          push_result(8'h00, 1'b0, 1'b1);
        end else begin
          tail      = expected_text.pop_back();
          tail.last = 1'b1;
          expected_text.push_back(tail);
        end
      end
    endfunction

    function void check_result(bit [7:0] data, bit present, bit last);
      text_result_t exp_r;
      if (expected_text.size() == 0) begin
        $display("%0t: unexpected output: out_byte expected none, actual %h", $time, data);
        errors++;
        return;
      end
      exp_r = expected_text.pop_front();
      if (exp_r.data != data) begin
        $display("%0t: out_byte mismatch: expected %h, actual %h", $time, exp_r.data, data);
        errors++;
      end
      if (exp_r.present != present) begin
        $display("%0t: byte_present mismatch: expected %b, actual %b",
                 $time, exp_r.present, present);
        errors++;
      end
      if (exp_r.last != last) begin
        $display("%0t: out_last mismatch: expected %b, actual %b", $time, exp_r.last, last);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_wdata;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [7:0] data_byte
  logic        in_tlast;   // end_of_text
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;  // [7:0] out_byte
  logic        out_tuser;  // byte_present
  logic        out_tlast;  // out_last

  text_replacer_sb sb;
  bit              calm;
  bit              in_held;
  int              items_sent;
  int              stall_left;
  int unsigned     roll;
  bit [7:0]        feed_q[$];

  byte_stream_find_replace uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mostly short gaps, the odd long one, none at all in a calm stretch.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Result side: check each accepted transaction and stall the block at random.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_result(out_tdata, out_tuser, out_tlast);
    end
    if (calm) begin
      out_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 70) begin
        out_tready <= 1'b1;
      end else begin
        stall_left = (roll < 95) ? $urandom_range(0, 2) : $urandom_range(10, 30);
        out_tready <= 1'b0;
      end
    end
  end

  // Hold one byte until the block takes it, then perhaps leave a gap.
  task automatic send_item(bit [7:0] b, bit eot);
    int unsigned gap;
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= eot;
    in_held   = 1'b1;
    do @(posedge clk); while (!in_tready);
    sb.note_input(b, eot);
    items_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      in_held   = 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_reg(cfg_reg_e idx, bit [63:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    sb.write_reg(idx, value);
  endtask

  // Writes all six registers back to back; length words carry junk above bit 4.
  task automatic configure(bit [4:0] plen, bit [127:0] pat, bit [4:0] rlen, bit [127:0] rep);
    bit [63:0] len_word;
    len_word      = {$urandom, $urandom};
    len_word[4:0] = plen;
    write_reg(REG_PAT_LEN, len_word);
    write_reg(REG_PAT_LO, pat[63:0]);
    write_reg(REG_PAT_HI, pat[127:64]);
    len_word      = {$urandom, $urandom};
    len_word[4:0] = rlen;
    write_reg(REG_REP_LEN, len_word);
    write_reg(REG_REP_LO, rep[63:0]);
    write_reg(REG_REP_HI, rep[127:64]);
    cfg_we <= 1'b0;
  endtask

  // Wait for every expected transaction, then let the pipeline settle.
  task automatic end_phase();
    if (in_held) begin
      in_tvalid <= 1'b0;
      in_held   = 1'b0;
    end
    while (sb.expected_text.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Text content: whole patterns, broken prefixes, pattern bytes and noise.
  task automatic refill_feed();
    int unsigned plen;
    int unsigned r;
    int unsigned cut;
    plen = sb.eff_len(sb.pat_len_reg);
    r    = $urandom_range(0, 99);
    if (plen > 0 && r < 45) begin
      for (int unsigned i = 0; i < plen; i++) feed_q.push_back(sb.pick_byte(sb.pat_lo, sb.pat_hi, i));
    end else if (plen > 1 && r < 60) begin
      cut = $urandom_range(1, plen - 1);
      for (int unsigned i = 0; i < cut; i++) feed_q.push_back(sb.pick_byte(sb.pat_lo, sb.pat_hi, i));
    end else if (plen > 0 && r < 80) begin
      feed_q.push_back(sb.pick_byte(sb.pat_lo, sb.pat_hi, $urandom_range(0, plen - 1)));
    end else begin
      feed_q.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic send_text(int unsigned len, bit close);
    bit [7:0] b;
    for (int unsigned k = 0; k < len; k++) begin
      if (feed_q.size() == 0) refill_feed();
      b = feed_q.pop_front();
      send_item(b, close && (k == len - 1));
    end
  endtask

  // One random setting followed by a batch of texts.
  task automatic run_random_phase();
    bit [4:0]    plen;
    bit [4:0]    rlen;
    bit [127:0]  pat;
    bit [127:0]  rep;
    int unsigned r;
    int unsigned budget;
    int unsigned sent;
    int unsigned len;
    bit          close;
    r = $urandom_range(0, 19);
    if (r == 0) plen = 5'd0;
    else if (r == 1) plen = 5'($urandom_range(17, 31));
    else if (r < 5) plen = 5'($urandom_range(5, 16));
    else plen = 5'($urandom_range(1, 4));
    if ($urandom_range(0, 1) == 1) begin
      for (int i = 0; i < 16; i++) pat[8*i +: 8] = 8'h61 + 8'($urandom_range(0, 2));
    end else begin
      pat = {$urandom, $urandom, $urandom, $urandom};
    end
    r = $urandom_range(0, 19);
    if (r < 2) rlen = 5'd0;
    else if (r == 2) rlen = 5'($urandom_range(17, 31));
    else rlen = 5'($urandom_range(1, 16));
    rep = {$urandom, $urandom, $urandom, $urandom};
    configure(plen, pat, rlen, rep);
    feed_q.delete();
    calm   = ($urandom_range(0, 3) == 0);
    budget = $urandom_range(20, 50);
    sent   = 0;
    while (sent < budget) begin
      len   = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 24);
      // Now and then the phase ends inside a text, so the rewrite drops the window.
      close = !((sent + len >= budget) && ($urandom_range(0, 3) == 0));
      send_text(len, close);
      sent += len;
    end
    end_phase();
    calm = 1'b0;
  endtask

  initial begin
    sb         = new();
    calm       = 1'b0;
    in_held    = 1'b0;
    items_sent = 0;
    stall_left = 0;
    rst_n      <= 1'b0;
    cfg_we     <= 1'b0;
    cfg_index  <= REG_PAT_LEN;
    cfg_wdata  <= '0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tlast   <= 1'b0;
    out_tready <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Reset values: zero pattern length passes bytes straight through.
    send_item(8'h00, 1'b0);
    send_item(8'hff, 1'b1);
    end_phase();

    // "ab" becomes "XYZ", followed by a flush of the trailing byte.
    configure(5'd2, 128'h6261, 5'd3, 128'h5a5958);
    send_item(8'h61, 1'b0);
    send_item(8'h62, 1'b0);
    send_item(8'h78, 1'b1);
    end_phase();

    // A dangling "a" must be dropped by the rewrite, so "b" cannot complete a match.
    send_item(8'h61, 1'b0);
    end_phase();
    configure(5'd2, 128'h6261, 5'd0, {$urandom, $urandom, $urandom, $urandom});
    send_item(8'h62, 1'b1);
    // Deleted match at the end of text leaves only a bare end marker.
    send_item(8'h61, 1'b0);
    send_item(8'h62, 1'b1);
    end_phase();

    // Oversized lengths saturate at sixteen bytes.
    configure(5'd31, '1, 5'd20, {$urandom, $urandom, $urandom, $urandom});
    for (int i = 0; i < 16; i++) send_item(8'hff, i == 15);
    end_phase();

    while (items_sent < TARGET_ITEMS) run_random_phase();

    if (sb.errors == 0) begin
      $display("byte_stream_find_replace_tb passed");
    end else begin
      $display("byte_stream_find_replace_tb failed");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #10_000_000;
    $display("byte_stream_find_replace_tb failed");
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/bsfr_pkg.sv
hw/rtl/bsfr_front.sv
hw/rtl/bsfr_queue.sv
hw/rtl/bsfr_back.sv
hw/rtl/byte_stream_find_replace.sv
bench/byte_stream_find_replace_tb.sv
